// File: rtl/hndc_pkg.sv
// Package for the header nonce double SHA-256 checker.
// Holds the SHA-256 constants, word types, register codes and helper functions.
// Used by the interfaces, the compression pipeline and the top level.
package hndc_pkg;

  typedef logic [31:0] word_t;
  typedef logic [7:0][31:0] state_t;
  typedef logic [15:0][31:0] block_t;

  localparam int unsigned NonceW   = 32;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned Rounds   = 64;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MERKLE0 = 3'd0,
    REG_MERKLE1 = 3'd1,
    REG_MERKLE2 = 3'd2,
    REG_MERKLE3 = 3'd3,
    REG_TIME    = 3'd4,
    REG_BITS    = 3'd5,
    REG_VERSION = 3'd6
  } cfg_reg_e;

  localparam logic [31:0] VersionReset = 32'h0000_0001;
  localparam logic [22:0] MantMask     = 23'h7f_ffff;
  localparam logic [31:0] PadOne       = 32'h8000_0000;
  localparam logic [31:0] LenHeader    = 32'h0000_0280;
  localparam logic [31:0] LenDigest    = 32'h0000_0100;

  localparam state_t HInit = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [63:0][31:0] KRound = {
    32'hc67178f2, 32'hbef9a3f7, 32'ha4506ceb, 32'h90befffa,
    32'h8cc70208, 32'h84c87814, 32'h78a5636f, 32'h748f82ee,
    32'h682e6ff3, 32'h5b9cca4f, 32'h4ed8aa4a, 32'h391c0cb3,
    32'h34b0bcb5, 32'h2748774c, 32'h1e376c08, 32'h19a4c116,
    32'h106aa070, 32'hf40e3585, 32'hd6990624, 32'hd192e819,
    32'hc76c51a3, 32'hc24b8b70, 32'ha81a664b, 32'ha2bfe8a1,
    32'h92722c85, 32'h81c2c92e, 32'h766a0abb, 32'h650a7354,
    32'h53380d13, 32'h4d2c6dfc, 32'h2e1b2138, 32'h27b70a85,
    32'h14292967, 32'h06ca6351, 32'hd5a79147, 32'hc6e00bf3,
    32'hbf597fc7, 32'hb00327c8, 32'ha831c66d, 32'h983e5152,
    32'h76f988da, 32'h5cb0a9dc, 32'h4a7484aa, 32'h2de92c6f,
    32'h240ca1cc, 32'h0fc19dc6, 32'hefbe4786, 32'he49b69c1,
    32'hc19bf174, 32'h9bdc06a7, 32'h80deb1fe, 32'h72be5d74,
    32'h550c7dc3, 32'h243185be, 32'h12835b01, 32'hd807aa98,
    32'hab1c5ed5, 32'h923f82a4, 32'h59f111f1, 32'h3956c25b,
    32'he9b5dba5, 32'hb5c0fbcf, 32'h71374491, 32'h428a2f98
  };

  function automatic word_t bswap(input word_t x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

  function automatic word_t big_sigma0(input word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage

// File: rtl/hndc_if.sv
// Valid/ready channel interfaces for the nonce checker.
// Depends on hndc_pkg for widths.
interface hndc_nonce_if;
  logic                         valid;
  logic                         ready;
  logic [hndc_pkg::NonceW-1:0]  nonce;
  modport source (output valid, output nonce, input ready);
  modport sink (input valid, input nonce, output ready);
endinterface

interface hndc_result_if;
  logic                         valid;
  logic                         ready;
  logic [hndc_pkg::NonceW-1:0]  nonce_echo;
  logic                         meets_target;
  logic [63:0]                  hash_word0;
  logic [63:0]                  hash_word1;
  logic [63:0]                  hash_word2;
  logic [63:0]                  hash_word3;
  modport source (output valid, output nonce_echo, output meets_target, output hash_word0,
                  output hash_word1, output hash_word2, output hash_word3, input ready);
  modport sink (input valid, input nonce_echo, input meets_target, input hash_word0,
                input hash_word1, input hash_word2, input hash_word3, output ready);
endinterface

interface hndc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [hndc_pkg::CfgIdxW-1:0]   index;
  logic [hndc_pkg::CfgDataW-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/hndc_compress.sv
// Fully unrolled SHA-256 compression: one register stage per round plus a final add stage.
// Depends on hndc_pkg for constants, types and the sigma functions.
module hndc_compress (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  hndc_pkg::state_t             state_i,
  input  hndc_pkg::block_t             block_i,
  input  logic [hndc_pkg::NonceW-1:0]  tag_i,
  output logic                         valid_o,
  output hndc_pkg::state_t             state_o,
  output logic [hndc_pkg::NonceW-1:0]  tag_o
);
  import hndc_pkg::*;

  // Index 0 is the input side, index r+1 the register after round r.
  logic                valid_w [0:Rounds];
  state_t              work_w  [0:Rounds];
  state_t              init_w  [0:Rounds];
  block_t              win_w   [0:Rounds];
  logic [NonceW-1:0]   tag_w   [0:Rounds];

  logic                valid_q;
  state_t              state_q;
  logic [NonceW-1:0]   tag_q;

  assign valid_w[0] = valid_i;
  assign work_w[0]  = state_i;
  assign init_w[0]  = state_i;
  assign win_w[0]   = block_i;
  assign tag_w[0]   = tag_i;

  for (genvar r = 0; r < Rounds; r++) begin : g_round
    logic    valid_q_r;
    state_t  work_q, work_d, init_q;
    block_t  win_q, win_d;
    logic [NonceW-1:0] tag_q_r;
    word_t   t1, t2, wa, wb, wc, we, wf, wg, wh;

    // State words are held as a..h in indices 0..7.
    always_comb begin
      wa = work_w[r][0];
      wb = work_w[r][1];
      wc = work_w[r][2];
      we = work_w[r][4];
      wf = work_w[r][5];
      wg = work_w[r][6];
      wh = work_w[r][7];
      t1 = wh + big_sigma1(we) + ((we & wf) ^ (~we & wg)) + KRound[r] + win_w[r][0];
      t2 = big_sigma0(wa) + ((wa & wb) ^ (wa & wc) ^ (wb & wc));
      work_d[0] = t1 + t2;
      work_d[1] = wa;
      work_d[2] = wb;
      work_d[3] = wc;
      work_d[4] = work_w[r][3] + t1;
      work_d[5] = we;
      work_d[6] = wf;
      work_d[7] = wg;
      // The schedule window slides by one word each round.
      win_d[14:0] = win_w[r][15:1];
      win_d[15]   = win_w[r][0] + small_sigma0(win_w[r][1]) + win_w[r][9]
                    + small_sigma1(win_w[r][14]);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q_r <= 1'b0;
      end else if (en_i) begin
        valid_q_r <= valid_w[r];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        work_q  <= work_d;
        init_q  <= init_w[r];
        win_q   <= win_d;
        tag_q_r <= tag_w[r];
      end
    end

    assign valid_w[r+1] = valid_q_r;
    assign work_w[r+1]  = work_q;
    assign init_w[r+1]  = init_q;
    assign win_w[r+1]   = win_q;
    assign tag_w[r+1]   = tag_q_r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_w[Rounds];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 8; i++) begin
        state_q[i] <= init_w[Rounds][i] + work_w[Rounds][i];
      end
      tag_q <= tag_w[Rounds];
    end
  end

  assign valid_o = valid_q;
  assign state_o = state_q;
  assign tag_o   = tag_q;

endmodule

// File: rtl/header_nonce_double_sha256_check.sv
// Pipeline: three compressions of 65 stages each, set by one register stage per SHA-256
// round, plus one compare stage, lie between the input transfer and the result.
// Throughput: one nonce per cycle; a stalled result holds the whole pipeline in place.
// Reset is asynchronous and active low; it clears all valid bits and the configuration
// registers (version to one, everything else to zero).
module header_nonce_double_sha256_check (
  input  logic          clk_i,
  input  logic          rst_ni,
  hndc_nonce_if.sink    nonce_i,
  hndc_result_if.source result_o,
  hndc_cfg_if.sink      cfg_i
);
  import hndc_pkg::*;

  logic [63:0] merkle0_q, merkle1_q, merkle2_q, merkle3_q;
  logic [31:0] time_q, bits_q, version_q;

  logic          out_valid_q;
  logic          en;

  block_t        blk1, blk2, blk3;
  logic          v1, v2, v3;
  state_t        s1, s2, s3;
  logic [NonceW-1:0] g1, g2, g3;

  logic [255:0]  target_q, target_d;
  logic          sat_q, sat_d;
  logic [255:0]  hv;

  logic [NonceW-1:0] nonce_q;
  logic          meets_q;
  logic [255:0]  hash_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      merkle0_q <= '0;
      merkle1_q <= '0;
      merkle2_q <= '0;
      merkle3_q <= '0;
      time_q    <= '0;
      bits_q    <= '0;
      version_q <= VersionReset;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_MERKLE0: merkle0_q <= cfg_i.data;
        REG_MERKLE1: merkle1_q <= cfg_i.data;
        REG_MERKLE2: merkle2_q <= cfg_i.data;
        REG_MERKLE3: merkle3_q <= cfg_i.data;
        REG_TIME:    time_q    <= cfg_i.data[31:0];
        REG_BITS:    bits_q    <= cfg_i.data[31:0];
        REG_VERSION: version_q <= cfg_i.data[31:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline advances together whenever the output register can move.
  assign en            = !out_valid_q || result_o.ready;
  assign nonce_i.ready = en;

  always_comb begin
    blk1     = '0;
    blk1[0]  = bswap(version_q);
    blk1[9]  = bswap(merkle0_q[31:0]);
    blk1[10] = bswap(merkle0_q[63:32]);
    blk1[11] = bswap(merkle1_q[31:0]);
    blk1[12] = bswap(merkle1_q[63:32]);
    blk1[13] = bswap(merkle2_q[31:0]);
    blk1[14] = bswap(merkle2_q[63:32]);
    blk1[15] = bswap(merkle3_q[31:0]);
  end

  always_comb begin
    blk2     = '0;
    blk2[0]  = bswap(merkle3_q[63:32]);
    blk2[1]  = bswap(time_q);
    blk2[2]  = bswap(bits_q);
    blk2[3]  = bswap(g1);
    blk2[4]  = PadOne;
    blk2[15] = LenHeader;
  end

  always_comb begin
    blk3       = '0;
    blk3[7:0]  = s2;
    blk3[8]    = PadOne;
    blk3[15]   = LenDigest;
  end

  hndc_compress u_first (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(nonce_i.valid), .state_i(HInit), .block_i(blk1), .tag_i(nonce_i.nonce),
    .valid_o(v1), .state_o(s1), .tag_o(g1)
  );

  hndc_compress u_second (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(v1), .state_i(s1), .block_i(blk2), .tag_i(g1),
    .valid_o(v2), .state_o(s2), .tag_o(g2)
  );

  hndc_compress u_outer (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(v2), .state_i(HInit), .block_i(blk3), .tag_i(g2),
    .valid_o(v3), .state_o(s3), .tag_o(g3)
  );

  // Target expansion from the compact bits; the register settles long before any result.
  always_comb begin
    logic [7:0]   ex;
    logic [22:0]  mant;
    logic [7:0]   sh;
    logic [278:0] wide;
    ex       = bits_q[31:24];
    mant     = bits_q[22:0] & MantMask;
    sh       = ex - 8'd3;
    wide     = {256'd0, mant} << {sh, 3'b000};
    target_d = '0;
    sat_d    = 1'b0;
    if (ex <= 8'd3) begin
      target_d = {233'd0, mant >> {2'(8'd3 - ex), 3'b000}};
    end else if (mant != '0) begin
      if (sh > 8'd32) begin
        sat_d = 1'b1;
      end else begin
        target_d = wide[255:0];
        sat_d    = (wide[278:256] != '0);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    target_q <= target_d;
    sat_q    <= sat_d;
  end

  // The digest is read as a little-endian integer.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      hv[32*i +: 32] = bswap(s3[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= v3;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nonce_q <= g3;
      hash_q  <= hv;
      meets_q <= sat_q || (hv <= target_q);
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.nonce_echo   = nonce_q;
  assign result_o.meets_target = meets_q;
  assign result_o.hash_word0   = hash_q[63:0];
  assign result_o.hash_word1   = hash_q[127:64];
  assign result_o.hash_word2   = hash_q[191:128];
  assign result_o.hash_word3   = hash_q[255:192];

endmodule

// File: tb/header_nonce_double_sha256_check_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the header nonce double SHA-256 checker.
// Predicts hash and target result per nonce; needs hndc_pkg, the channel interfaces and the block.
module header_nonce_double_sha256_check_test;
  import hndc_pkg::*;

  typedef struct packed {
    logic [31:0] nonce_echo;
    logic        meets_target;
    logic [63:0] hash_word0;
    logic [63:0] hash_word1;
    logic [63:0] hash_word2;
    logic [63:0] hash_word3;
  } pow_result_t;

  logic clk_i;
  logic rst_ni;

  hndc_nonce_if  nif();
  hndc_result_if rif();
  hndc_cfg_if    cif();

  header_nonce_double_sha256_check u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .nonce_i  (nif.sink),
    .result_o (rif.source),
    .cfg_i    (cif.sink)
  );

  // Own copy of the configuration, updated on each accepted register transfer.
  logic [63:0] mdl_merkle [4];
  logic [31:0] mdl_time;
  logic [31:0] mdl_bits;
  logic [31:0] mdl_version;

  logic [31:0] nonce_pending [$];
  pow_result_t results_due [$];

  int unsigned n_nonces;
  int unsigned n_results;
  int unsigned n_passing;
  int unsigned n_errors;
  int unsigned send_gap;
  int unsigned recv_gap;
  int unsigned hold_left;
  bit          hold_done;
  logic        nonce_took;
  logic        cfg_took;

  function automatic logic [255:0] sha_compress(input logic [255:0] st_in,
                                                input logic [511:0] blk);
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
    logic [255:0] st_out;
    for (int i = 0; i < 16; i++) w[i] = blk[511 - 32 * i -: 32];
    for (int i = 16; i < 64; i++) begin
      s0 = {w[i-15][6:0], w[i-15][31:7]} ^ {w[i-15][17:0], w[i-15][31:18]} ^ (w[i-15] >> 3);
      s1 = {w[i-2][16:0], w[i-2][31:17]} ^ {w[i-2][18:0], w[i-2][31:19]} ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    a = st_in[31:0];    b = st_in[63:32];   c = st_in[95:64];   d = st_in[127:96];
    e = st_in[159:128]; f = st_in[191:160]; g = st_in[223:192]; h = st_in[255:224];
    for (int i = 0; i < 64; i++) begin
      t1 = h + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
           + ((e & f) ^ (~e & g)) + KRound[i] + w[i];
      t2 = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
           + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    st_out = {st_in[255:224] + h, st_in[223:192] + g, st_in[191:160] + f,
              st_in[159:128] + e, st_in[127:96] + d, st_in[95:64] + c,
              st_in[63:32] + b, st_in[31:0] + a};
    return st_out;
  endfunction

  function automatic pow_result_t predict_pow(input logic [31:0] nonce);
    logic [7:0]   hdr [128];
    logic [1023:0] msg;
    logic [255:0] st;
    logic [255:0] dig_be;
    logic [255:0] hash_val;
    logic [287:0] target;
    logic [7:0]   ex;
    logic [22:0]  mant;
    bit           sat;
    pow_result_t  r;
    for (int j = 0; j < 128; j++) hdr[j] = 8'h00;
    for (int j = 0; j < 4; j++) begin
      hdr[j]      = mdl_version[8*j +: 8];
      hdr[68 + j] = mdl_time[8*j +: 8];
      hdr[72 + j] = mdl_bits[8*j +: 8];
      hdr[76 + j] = nonce[8*j +: 8];
    end
    for (int k = 0; k < 4; k++)
      for (int j = 0; j < 8; j++) hdr[36 + 8*k + j] = mdl_merkle[k][8*j +: 8];
    hdr[80]  = 8'h80;
    hdr[126] = 8'h02;
    hdr[127] = 8'h80;
    for (int j = 0; j < 128; j++) msg[1023 - 8*j -: 8] = hdr[j];
    st = HInit;
    st = sha_compress(st, msg[1023:512]);
    st = sha_compress(st, msg[511:0]);
    for (int i = 0; i < 8; i++) dig_be[255 - 32*i -: 32] = st[32*i +: 32];
    st = sha_compress(HInit, {dig_be, 8'h80, 184'd0, 64'h100});
    for (int i = 0; i < 8; i++) dig_be[255 - 32*i -: 32] = st[32*i +: 32];
    // The digest is read with its first byte as the least significant one.
    for (int j = 0; j < 32; j++) hash_val[8*j +: 8] = dig_be[255 - 8*j -: 8];

    ex     = mdl_bits[31:24];
    mant   = mdl_bits[22:0];
    sat    = 1'b0;
    target = '0;
    if (ex <= 8'd3) begin
      target = {265'd0, mant} >> (8 * (3 - ex));
    end else if (mant != 23'd0) begin
      if (ex >= 8'd35) begin
        sat = 1'b1;
      end else begin
        target = {265'd0, mant} << (8 * (ex - 3));
        if (target[287:256] != '0) sat = 1'b1;
      end
    end
    r.nonce_echo   = nonce;
    r.meets_target = sat || (hash_val <= target[255:0]);
    r.hash_word0   = hash_val[63:0];
    r.hash_word1   = hash_val[127:64];
    r.hash_word2   = hash_val[191:128];
    r.hash_word3   = hash_val[255:192];
    return r;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

  // Transfers are observed at the rising edge, before the block updates anything.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nonce_took  <= 1'b0;
      cfg_took    <= 1'b0;
      mdl_merkle[0] <= '0; mdl_merkle[1] <= '0; mdl_merkle[2] <= '0; mdl_merkle[3] <= '0;
      mdl_time    <= '0;
      mdl_bits    <= '0;
      mdl_version <= VersionReset;
    end else begin
      nonce_took <= nif.valid && nif.ready;
      cfg_took   <= cif.valid && cif.ready;
      if (cif.valid && cif.ready) begin
        case (cif.index)
          REG_MERKLE0: mdl_merkle[0] <= cif.data;
          REG_MERKLE1: mdl_merkle[1] <= cif.data;
          REG_MERKLE2: mdl_merkle[2] <= cif.data;
          REG_MERKLE3: mdl_merkle[3] <= cif.data;
          REG_TIME:    mdl_time      <= cif.data[31:0];
          REG_BITS:    mdl_bits      <= cif.data[31:0];
          REG_VERSION: mdl_version   <= cif.data[31:0];
          default: ;
        endcase
      end
      if (nif.valid && nif.ready) begin
        results_due = {results_due, predict_pow(nif.nonce)};
        n_nonces++;
      end
      if (rif.valid && rif.ready) begin
        pow_result_t got, want;
        got = '{rif.nonce_echo, rif.meets_target, rif.hash_word0, rif.hash_word1,
                rif.hash_word2, rif.hash_word3};
        n_results++;
        if (results_due.size() == 0) begin
          $display("%t: unexpected result, actual %h", $realtime, got);
          n_errors++;
        end else begin
          want = results_due.pop_front();
          if (got.meets_target) n_passing++;
          if (got !== want) begin
            $display("%t: mismatch nonce %h: expected %h, actual %h", $realtime,
                     want.nonce_echo, want, got);
            n_errors++;
          end
        end
      end
    end
  end

  // Idling pattern follows the number of nonces transferred so far.
  always @(negedge clk_i) begin
    if (n_nonces < 520) begin
      send_gap = 7;  recv_gap = 45;
    end else if (n_nonces < 1040) begin
      send_gap = 45; recv_gap = 7;
    end else begin
      send_gap = 0;  recv_gap = 0;
    end
    if (rst_ni) begin
      if (!nif.valid || nonce_took) begin
        if (nonce_pending.size() > 0 && $urandom_range(99) >= send_gap) begin
          nif.nonce <= nonce_pending.pop_front();
          nif.valid <= 1'b1;
        end else begin
          nif.valid <= 1'b0;
        end
      end
      if (!hold_done && n_nonces >= 1100) begin
        hold_done = 1'b1;
        hold_left = 600;
      end
      if (hold_left > 0) begin
        hold_left--;
        rif.ready <= 1'b0;
      end else begin
        rif.ready <= ($urandom_range(99) >= recv_gap);
      end
    end
  end

  task automatic write_reg(input cfg_reg_e idx, input logic [63:0] value);
    @(negedge clk_i);
    cif.index <= idx;
    cif.data  <= value;
    cif.valid <= 1'b1;
    do @(negedge clk_i); while (!cfg_took);
    cif.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (nonce_pending.size() > 0 || nif.valid || results_due.size() > 0);
    repeat (200) @(negedge clk_i);
  endtask

  task automatic add_nonce(input logic [31:0] value);
    nonce_pending = {nonce_pending, value};
  endtask

  task automatic queue_random(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) add_nonce($urandom);
  endtask

  logic [31:0] bits_set [9] = '{32'hffff_ffff, 32'h207f_ffff, 32'h2100_ffff, 32'h0312_3456,
                                32'h0100_3456, 32'h1d00_ffff, 32'h2200_0001, 32'h2300_0001,
                                32'h20ff_ffff};

  initial begin
    n_nonces = 0; n_results = 0; n_passing = 0; n_errors = 0;
    hold_left = 0; hold_done = 1'b0;
    nif.valid = 1'b0; nif.nonce = '0;
    rif.ready = 1'b0;
    cif.valid = 1'b0; cif.index = REG_MERKLE0; cif.data = '0;
    rst_ni = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset configuration: zero target, so only a zero hash could pass.
    add_nonce(32'h0000_0000);
    add_nonce(32'hffff_ffff);
    add_nonce(32'h0000_0001);
    add_nonce(32'h8000_0000);
    add_nonce(32'h5555_5555);
    add_nonce(32'haaaa_aaaa);
    wait_drained();

    // All fields at their maximum, with a saturating exponent.
    write_reg(REG_MERKLE0, '1); write_reg(REG_MERKLE1, '1);
    write_reg(REG_MERKLE2, '1); write_reg(REG_MERKLE3, '1);
    write_reg(REG_TIME, '1); write_reg(REG_VERSION, '1);
    write_reg(REG_BITS, 64'hffff_ffff_ffff_ffff);
    // A write to the unused index must leave everything as it was.
    write_reg(cfg_reg_e'(3'd7), 64'h0123_4567_89ab_cdef);
    add_nonce(32'h0000_0000);
    add_nonce(32'hffff_ffff);
    add_nonce(32'h1234_5678);
    wait_drained();

    // Each target shape in turn: saturating, large, right-shifted and sign bit set.
    foreach (bits_set[i]) begin
      for (int k = 0; k < 4; k++)
        write_reg(cfg_reg_e'(k), {$urandom, $urandom});
      write_reg(REG_TIME, {$urandom, $urandom});
      write_reg(REG_VERSION, {$urandom, $urandom});
      write_reg(REG_BITS, {32'hdead_beef, bits_set[i]});
      if (i == 3) add_nonce(32'h0000_0000);
      queue_random(i == 0 ? 10 : 187);
      wait_drained();
    end
    write_reg(REG_BITS, 64'h0400_0000);
    write_reg(REG_MERKLE0, '0);
    write_reg(REG_VERSION, '0);
    queue_random(30);
    wait_drained();

    $display("Checked %0d nonces against %0d results, %0d meeting the target,",
             n_nonces, n_results, n_passing);
    $display("across twelve configurations with saturating, shifted and zero targets.");
    if (n_errors == 0 && results_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/hndc_pkg.sv
rtl/hndc_if.sv
rtl/hndc_compress.sv
rtl/header_nonce_double_sha256_check.sv
tb/header_nonce_double_sha256_check_test.sv
